// ===== rtl/bounded_circular_list_macros.svh =====
// Assertion macros shared by the bounded circular list RTL.
`ifndef BOUNDED_CIRCULAR_LIST_MACROS_SVH
`define BOUNDED_CIRCULAR_LIST_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BCL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BCL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bcl_pkg.sv =====
// Shared types and constants of the bounded circular list.
package bcl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int COUNT_W  = 5;

  typedef enum logic [1:0] {
    ACT_INS_FRONT = 2'd0,
    ACT_INS_END   = 2'd1,
    ACT_DELETE    = 2'd2,
    ACT_DISPLAY   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // One access to the entry store: either a read or a write at addr.
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

endpackage

// ===== rtl/bcl_slot.sv =====
// Ring slot unit: (base + offset) modulo the list capacity.
module bcl_slot (
  input  logic [bcl_pkg::IDX_W-1:0] base,
  input  logic [bcl_pkg::IDX_W-1:0] offset,
  output logic [bcl_pkg::IDX_W-1:0] slot
);

  localparam int SUM_W = bcl_pkg::IDX_W + 1;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] wrapped;

  // Both operands are below the capacity, so one conditional subtract wraps.
  always_comb begin
    sum     = SUM_W'(base) + SUM_W'(offset);
    wrapped = sum - SUM_W'(bcl_pkg::CAPACITY);
    if (sum >= SUM_W'(bcl_pkg::CAPACITY)) begin
      slot = wrapped[bcl_pkg::IDX_W-1:0];
    end else begin
      slot = sum[bcl_pkg::IDX_W-1:0];
    end
  end

endmodule

// ===== rtl/bcl_mem.sv =====
// Entry store of the list: single-port memory with registered read data.
module bcl_mem (
  input  logic                       clk,
  input  bcl_pkg::mem_req_t          req,
  output logic [bcl_pkg::DATA_W-1:0] rdata
);

  logic [bcl_pkg::DATA_W-1:0] mem [bcl_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// ===== rtl/bounded_circular_list.sv =====
// Top level of the bounded circular list: sequencer, result register and unit hookup.
//
//   channel  | dir | tdata (low bit up)                  | tuser / tlast
//   ---------+-----+-------------------------------------+------------------------------
//   s_axis   | in  | value[31:0], position[39:32]        | tuser: action[1:0]
//   m_axis   | out | entry_value[31:0], count[36:32]     | tuser: status[1:0],
//            |     |                                     |   entry_valid[2]; tlast: last
//
// A request is taken only while the sequencer is idle; it then keeps s_axis_tready low
// until every result of that request has been loaded into the output register.
// Insert: the decode step does the work, then the single result follows. Delete of an
// inner entry: the decode step, then a read and a write per entry moved up through
// the single memory port, then the result. Display: a read, then an emit, per entry.
// The shared memory port and the single slot adder serialise these steps. Output stalls
// only hold the sequencer where a result is due; a new request may be taken while the
// last result still waits in m_axis.
// Reset (rst, synchronous) empties the list; entry contents are not cleared.
module bounded_circular_list (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // value[31:0], position[39:32]
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // entry_value[31:0], count[36:32], zero fill
  output logic [2:0]  m_axis_tuser,  // status[1:0], entry_valid[2]
  output logic        m_axis_tlast   // last result of the request
);

  localparam int IDX_W  = bcl_pkg::IDX_W;
  localparam int CNT_W  = bcl_pkg::CNT_W;
  localparam int DATA_W = bcl_pkg::DATA_W;
  localparam int POS_W  = bcl_pkg::POS_W;
  localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,    // waiting for a request
    S_EXEC,    // decode the action, do inserts and simple deletes
    S_SH_RD,   // delete: read the entry one place further back
    S_SH_WR,   // delete: write it one place forward
    S_DS_RD,   // display: read the next entry
    S_DS_OUT,  // display: hand the entry to the output register
    S_RESP     // single status result of insert, delete or empty display
  } state_t;

  state_t                 state;
  bcl_pkg::action_t       act;
  logic [DATA_W-1:0]      val;
  logic [POS_W-1:0]       pos;
  bcl_pkg::status_t       st;
  logic [IDX_W-1:0]       front;
  logic [CNT_W-1:0]       count;
  logic [IDX_W-1:0]       k;

  // Output register.
  logic                   out_valid;
  bcl_pkg::status_t       out_status;
  logic                   out_entry_valid;
  logic [DATA_W-1:0]      out_value;
  logic                   out_last;
  logic [bcl_pkg::COUNT_W-1:0] out_count;

  logic                   out_free;
  logic                   out_load;
  logic                   full;
  logic                   pos_bad;
  logic                   pos_tail;
  logic [IDX_W-1:0]       unit_off;
  logic [IDX_W-1:0]       slot;
  bcl_pkg::mem_req_t      mem_req;
  logic [DATA_W-1:0]      rdata;

  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !out_valid || m_axis_tready;
  // A result is loaded into the output register in this cycle.
  assign out_load      = ((state == S_DS_OUT) || (state == S_RESP)) && out_free;

  assign full     = (count == CNT_W'(bcl_pkg::CAPACITY));
  assign pos_bad  = (CMP_W'(pos) >= CMP_W'(count));
  // The deleted entry is the back one, so nothing has to move up.
  assign pos_tail = (CMP_W'(pos) == CMP_W'(count) - CMP_W'(1));

  bcl_slot u_slot (
    .base   (front),
    .offset (unit_off),
    .slot   (slot)
  );

  bcl_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // Operand select for the slot unit and the memory access of this cycle.
  always_comb begin
    unit_off      = '0;
    mem_req.rd_en = 1'b0;
    mem_req.wr_en = 1'b0;
    mem_req.addr  = slot;
    mem_req.wdata = val;
    case (state)
      S_EXEC: begin
        case (act)
          bcl_pkg::ACT_INS_FRONT: begin
            unit_off      = IDX_W'(bcl_pkg::CAPACITY - 1);
            mem_req.wr_en = !full;
          end
          bcl_pkg::ACT_INS_END: begin
            unit_off      = count[IDX_W-1:0];
            mem_req.wr_en = !full;
          end
          bcl_pkg::ACT_DELETE: begin
            unit_off = IDX_W'(1);
          end
          default: begin
            unit_off = '0;
          end
        endcase
      end
      S_SH_RD: begin
        unit_off      = k + IDX_W'(1);
        mem_req.rd_en = 1'b1;
      end
      S_SH_WR: begin
        unit_off      = k;
        mem_req.wr_en = 1'b1;
        mem_req.wdata = rdata;
      end
      S_DS_RD: begin
        unit_off      = k;
        mem_req.rd_en = 1'b1;
      end
      default: begin
        unit_off = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            act   <= bcl_pkg::action_t'(s_axis_tuser);
            val   <= s_axis_tdata[DATA_W-1:0];
            pos   <= s_axis_tdata[DATA_W +: POS_W];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (act)
            bcl_pkg::ACT_INS_FRONT: begin
              state <= S_RESP;
              if (full) begin
                st <= bcl_pkg::ST_FULL;
              end else begin
                st    <= bcl_pkg::ST_OK;
                front <= slot;
                count <= count + CNT_W'(1);
              end
            end
            bcl_pkg::ACT_INS_END: begin
              state <= S_RESP;
              if (full) begin
                st <= bcl_pkg::ST_FULL;
              end else begin
                st    <= bcl_pkg::ST_OK;
                count <= count + CNT_W'(1);
              end
            end
            bcl_pkg::ACT_DELETE: begin
              if (pos_bad) begin
                st    <= bcl_pkg::ST_RANGE;
                state <= S_RESP;
              end else if (pos == '0) begin
                // Dropping the front entry just advances the ring start.
                st    <= bcl_pkg::ST_OK;
                front <= slot;
                count <= count - CNT_W'(1);
                state <= S_RESP;
              end else if (pos_tail) begin
                st    <= bcl_pkg::ST_OK;
                count <= count - CNT_W'(1);
                state <= S_RESP;
              end else begin
                st    <= bcl_pkg::ST_OK;
                k     <= pos[IDX_W-1:0];
                state <= S_SH_RD;
              end
            end
            default: begin
              // Display: an empty list answers with the single status result.
              st <= bcl_pkg::ST_OK;
              if (count != '0) begin
                k     <= '0;
                state <= S_DS_RD;
              end else begin
                state <= S_RESP;
              end
            end
          endcase
        end
        S_SH_RD: begin
          state <= S_SH_WR;
        end
        S_SH_WR: begin
          if (CNT_W'(k) + CNT_W'(2) == count) begin
            count <= count - CNT_W'(1);
            state <= S_RESP;
          end else begin
            k     <= k + IDX_W'(1);
            state <= S_SH_RD;
          end
        end
        S_DS_RD: begin
          state <= S_DS_OUT;
        end
        S_DS_OUT: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            out_status      <= bcl_pkg::ST_OK;
            out_entry_valid <= 1'b1;
            out_value       <= rdata;
            out_last        <= (CNT_W'(k) + CNT_W'(1) == count);
            out_count       <= bcl_pkg::COUNT_W'(count);
            if (CNT_W'(k) + CNT_W'(1) == count) begin
              state <= S_IDLE;
            end else begin
              k     <= k + IDX_W'(1);
              state <= S_DS_RD;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            out_status      <= st;
            out_entry_valid <= 1'b0;
            out_value       <= '0;
            out_last        <= 1'b1;
            out_count       <= bcl_pkg::COUNT_W'(count);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_count, out_value};
  assign m_axis_tuser  = {out_entry_valid, out_status};
  assign m_axis_tlast  = out_last;

`include "bounded_circular_list_macros.svh"

  // The list never holds more entries than the ring has slots.
  `BCL_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(bcl_pkg::CAPACITY), "count high")

  // Only the decode step and the last shift step change the entry count.
  `BCL_ASSERT_NEXT(a_count_steady, clk, rst, state != S_EXEC && state != S_SH_WR, $stable(count), "count")

  // A result without a list element is always the only result of its request.
  `BCL_ASSERT_NOW(a_status_last, clk, rst, out_valid && !out_entry_valid, out_last, "not last")

  // Display results always carry an ok status.
  `BCL_ASSERT_NOW(a_entry_ok, clk, rst, out_valid && out_entry_valid, out_status == bcl_pkg::ST_OK, "status")

  // Once a request is taken, no other is taken in the next cycle.
  `BCL_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "busy")

endmodule
